// File: rtl/csa_pkg.sv
// shared types and constants for the contiguous segment allocator
// no dependencies
package csa_pkg;
	localparam int MAX_PROCESSES_DEF = 10;
	localparam int ADDR_BITS_DEF = 16;
	localparam int MEM_WIDTH = 16;
	localparam logic [15:0] MEM_RESET = 16'd8000;
	localparam logic [15:0] MIN_SEGMENT = 16'd2;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_STOP = 2'd1,
		ACT_LOCATE = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_ACTIVE = 3'd1,
		ST_NOSPACE = 3'd2,
		ST_SMALL = 3'd3,
		ST_INACTIVE = 3'd4,
		ST_OFFSET = 3'd5
	} status_t;

	// datapath commands
	typedef enum logic [3:0] {
		CMD_IDLE,
		CMD_LOAD,
		CMD_SUM,
		CMD_TAIL,
		CMD_GAP,
		CMD_PACK,
		CMD_COMMIT,
		CMD_STOP,
		CMD_LOCATE,
		CMD_RESULT
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic clr_idx;
		logic set_idx_top;
	} dp_ctrl_t;

	typedef struct packed {
		logic id_ok;
		logic id_valid;
		logic idx_last;
		logic idx_done;
		logic gap_hit;
		logic tail_fit;
		logic no_space;
		logic too_small;
		logic off_bad;
		logic has_live;
	} dp_stat_t;
endpackage

// File: rtl/csa_if.sv
// valid/ready channel interfaces for the allocator
// depends on csa_pkg
interface csa_req_if import csa_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [3:0] process_id;
	logic [15:0] amount;
	modport source(output valid, action, process_id, amount, input ready);
	modport sink(input valid, action, process_id, amount, output ready);
endinterface

interface csa_rsp_if #(parameter int ADDR_BITS = 16) ();
	logic valid;
	logic ready;
	logic [ADDR_BITS-1:0] address;
	logic [2:0] status;
	logic compacted;
	modport source(output valid, address, status, compacted, input ready);
	modport sink(input valid, address, status, compacted, output ready);
endinterface

// File: rtl/csa_datapath.sv
// segment tables, age list and the adders and compares of the allocator
// depends on csa_pkg
module csa_datapath import csa_pkg::*; #(
	parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input dp_ctrl_t ctrl,
	output dp_stat_t stat,
	input logic [3:0] process_id,
	input logic [15:0] amount,
	input logic [15:0] memory_words,
	output logic [ADDR_BITS-1:0] res_address,
	output logic [2:0] res_status,
	output logic res_compacted
);
	localparam int IW = $clog2(MAX_PROCESSES);
	localparam int CW = $clog2(MAX_PROCESSES + 1);
	localparam int SW = ADDR_BITS + CW + 1;

	logic [MAX_PROCESSES-1:0] valid_q;
	logic [ADDR_BITS-1:0] base_q [MAX_PROCESSES];
	logic [15:0] len_q [MAX_PROCESSES];
	logic [IW-1:0] age_q [MAX_PROCESSES];
	logic [CW-1:0] live_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] wr_q;
	logic [IW-1:0] id_q;
	logic [3:0] pid_q;
	logic [15:0] amt_q;
	logic [SW-1:0] sum_q;
	logic [SW-1:0] run_q;
	logic [ADDR_BITS-1:0] place_q;
	logic placed_q;
	logic packed_q;
	logic [2:0] st_q;

	logic [IW-1:0] a_cur, a_prev, a_new;
	logic [SW-1:0] cur_end, prev_end, free_w;
	logic id_ok;

	assign id_ok = {1'b0, pid_q} < 5'(MAX_PROCESSES);
	assign a_cur = age_q[idx_q[IW-1:0]];
	assign a_prev = age_q[idx_q[IW-1:0] - 1'b1];
	assign a_new = age_q[live_q[IW-1:0] - 1'b1];
	assign cur_end = SW'(base_q[a_new]) + SW'(len_q[a_new]);
	assign prev_end = SW'(base_q[a_prev]) + SW'(len_q[a_prev]);
	assign free_w = (sum_q >= SW'(memory_words)) ? '0 : SW'(memory_words) - sum_q;

	always_comb begin
		stat.id_ok = id_ok;
		stat.id_valid = id_ok && valid_q[pid_q[IW-1:0]];
		stat.idx_last = (idx_q == live_q);
		stat.idx_done = (idx_q == '0);
		stat.gap_hit = (prev_end < SW'(base_q[a_cur]))
			&& (SW'(base_q[a_cur]) - prev_end >= SW'(amt_q));
		stat.tail_fit = (cur_end + SW'(amt_q) <= SW'(memory_words));
		stat.no_space = (free_w < SW'(amt_q));
		stat.too_small = (amt_q < MIN_SEGMENT) || (live_q >= CW'(MAX_PROCESSES));
		stat.off_bad = amt_q >= len_q[id_q];
		stat.has_live = live_q != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			live_q <= '0;
			idx_q <= '0;
			wr_q <= '0;
			placed_q <= 1'b0;
			packed_q <= 1'b0;
			st_q <= ST_OK;
		end else begin
			if (ctrl.clr_idx) idx_q <= '0;
			if (ctrl.set_idx_top) idx_q <= live_q - 1'b1;
			case (ctrl.cmd)
				CMD_LOAD: begin
					id_q <= process_id[IW-1:0];
					pid_q <= process_id;
					amt_q <= amount;
					sum_q <= '0;
					run_q <= '0;
					wr_q <= '0;
					placed_q <= 1'b0;
					packed_q <= 1'b0;
					place_q <= '0;
					st_q <= ST_OK;
				end
				CMD_SUM: begin
					if (!stat.idx_last) begin
						sum_q <= sum_q + SW'(len_q[a_cur]);
						idx_q <= idx_q + 1'b1;
					end
				end
				CMD_TAIL: begin
					if (stat.tail_fit) begin
						place_q <= cur_end[ADDR_BITS-1:0];
						placed_q <= 1'b1;
					end
				end
				CMD_GAP: begin
					if (!placed_q && !stat.idx_done) begin
						if (stat.gap_hit) begin
							place_q <= prev_end[ADDR_BITS-1:0];
							placed_q <= 1'b1;
						end
						idx_q <= idx_q - 1'b1;
					end
				end
				CMD_PACK: begin
					if (!stat.idx_last) begin
						base_q[a_cur] <= run_q[ADDR_BITS-1:0];
						run_q <= run_q + SW'(len_q[a_cur]);
						idx_q <= idx_q + 1'b1;
					end else begin
						place_q <= run_q[ADDR_BITS-1:0];
						packed_q <= 1'b1;
					end
				end
				CMD_COMMIT: begin
					valid_q[id_q] <= 1'b1;
					base_q[id_q] <= place_q;
					len_q[id_q] <= amt_q;
					age_q[live_q[IW-1:0]] <= id_q;
					live_q <= live_q + 1'b1;
				end
				CMD_STOP: begin
					// compact the age list one entry a cycle
					if (!stat.idx_last) begin
						if (a_cur != id_q) begin
							age_q[wr_q[IW-1:0]] <= a_cur;
							wr_q <= wr_q + 1'b1;
						end
						idx_q <= idx_q + 1'b1;
					end else begin
						valid_q[id_q] <= 1'b0;
						live_q <= wr_q;
					end
				end
				CMD_LOCATE: begin
					place_q <= base_q[id_q] + ADDR_BITS'(amt_q);
				end
				CMD_RESULT: begin
					st_q <= st_q;
				end
				default: begin
				end
			endcase
		end
	end

	// this status only holds ST_OK from the load; the top takes status from the controller
	logic [2:0] st_w;
	assign st_w = st_q;
	assign res_address = place_q;
	assign res_status = st_w;
	assign res_compacted = packed_q;
endmodule

// File: rtl/csa_ctrl.sv
// sequencer for start, stop and locate of the allocator
// depends on csa_pkg
module csa_ctrl import csa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] action,
	input dp_stat_t stat,
	output dp_ctrl_t ctrl,
	input logic out_ready,
	output logic out_valid,
	output logic [2:0] out_status,
	output logic out_zero
);
	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_SUM, S_CHECK, S_TAIL, S_GAP, S_PACK,
		S_COMMIT, S_STOP, S_LOCATE, S_DONE
	} state_t;

	state_t state_q;
	action_t act_q;
	logic [2:0] st_q;
	logic zero_q;

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		ctrl = '{cmd: CMD_IDLE, clr_idx: 1'b0, set_idx_top: 1'b0};
		case (state_q)
			S_IDLE: if (in_valid && in_ready) ctrl = '{CMD_LOAD, 1'b1, 1'b0};
			S_SUM: ctrl.cmd = CMD_SUM;
			S_CHECK: ctrl.set_idx_top = 1'b1;
			S_TAIL: ctrl.cmd = CMD_TAIL;
			S_GAP: begin
				ctrl.cmd = CMD_GAP;
				if (stat.idx_done) ctrl.clr_idx = 1'b1;
			end
			S_PACK: ctrl.cmd = CMD_PACK;
			S_COMMIT: ctrl.cmd = CMD_COMMIT;
			S_STOP: ctrl.cmd = CMD_STOP;
			S_LOCATE: ctrl.cmd = CMD_LOCATE;
			default: ctrl.cmd = CMD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= ACT_NONE;
			st_q <= ST_OK;
			zero_q <= 1'b1;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					act_q <= action_t'(action);
					state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					// stat here reflects latched id/amount
					case (act_q)
						ACT_START: begin
							if (stat.id_valid) begin
								st_q <= ST_ACTIVE;
								state_q <= S_DONE;
							end else begin
								state_q <= S_SUM;
							end
						end
						ACT_STOP: begin
							if (!stat.id_valid) begin
								st_q <= ST_INACTIVE;
								state_q <= S_DONE;
							end else begin
								st_q <= ST_OK;
								state_q <= S_STOP;
							end
						end
						ACT_LOCATE: begin
							if (!stat.id_valid) begin
								st_q <= ST_INACTIVE;
								state_q <= S_DONE;
							end else if (stat.off_bad) begin
								st_q <= ST_OFFSET;
								state_q <= S_DONE;
							end else begin
								st_q <= ST_OK;
								state_q <= S_LOCATE;
							end
						end
						default: begin
							st_q <= ST_OK;
							state_q <= S_DONE;
						end
					endcase
				end
				S_SUM: if (stat.idx_last) state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.no_space) begin
						st_q <= ST_NOSPACE;
						state_q <= S_DONE;
					end else if (stat.too_small || !stat.id_ok) begin
						st_q <= ST_SMALL;
						state_q <= S_DONE;
					end else begin
						st_q <= ST_OK;
						state_q <= stat.has_live ? S_TAIL : S_COMMIT;
					end
				end
				S_TAIL: state_q <= stat.tail_fit ? S_COMMIT : S_GAP;
				S_GAP: begin
					if (stat.gap_hit && !stat.idx_done) state_q <= S_COMMIT;
					else if (stat.idx_done) state_q <= S_PACK;
				end
				S_PACK: if (stat.idx_last) state_q <= S_COMMIT;
				S_COMMIT: begin
					zero_q <= 1'b0;
					state_q <= S_DONE;
				end
				S_STOP: if (stat.idx_last) begin
					zero_q <= 1'b1;
					state_q <= S_DONE;
				end
				S_LOCATE: begin
					zero_q <= 1'b0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_DISPATCH) zero_q <= 1'b1;
		end
	end

	assign out_status = st_q;
	assign out_zero = zero_q;
endmodule

// File: rtl/contiguous_segment_allocator_core.sv
// top level of the contiguous segment allocator
// depends on csa_pkg, csa_if, csa_ctrl, csa_datapath
//
// channel | dir | fields
// req     | in  | action, process_id, amount
// rsp     | out | address, status, compacted
// cfg     | in  | cfg_we, cfg_data (memory_words)
//
// one word at a time. a start sums the live segment lengths, then tries the end of the
// newest segment, then the gaps between segments from newest to oldest, and else
// repacks all segments from address 0 and places the new one after them; a stop
// closes up the age list and a locate adds the offset to the segment base.
// the result sits in an output register and the next word is taken from the
// edge after it is gone. arst_n clears all segments.
module contiguous_segment_allocator_core import csa_pkg::*; #(
	parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [15:0] cfg_data,
	csa_req_if.sink req,
	csa_rsp_if.source rsp
);
	logic [15:0] mem_words_q;
	dp_ctrl_t ctrl;
	dp_stat_t stat;
	logic [ADDR_BITS-1:0] dp_addr;
	logic [2:0] dp_st, c_st;
	logic dp_pk, zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mem_words_q <= MEM_RESET;
		else if (cfg_we) mem_words_q <= cfg_data;
	end

	csa_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready), .action(req.action),
		.stat, .ctrl,
		.out_ready(rsp.ready), .out_valid(rsp.valid),
		.out_status(c_st), .out_zero(zero)
	);

	csa_datapath #(.MAX_PROCESSES(MAX_PROCESSES), .ADDR_BITS(ADDR_BITS)) u_dp (
		.clk, .arst_n, .ctrl, .stat,
		.process_id(req.process_id), .amount(req.amount),
		.memory_words(mem_words_q),
		.res_address(dp_addr), .res_status(dp_st), .res_compacted(dp_pk)
	);

	assign rsp.status = c_st | (dp_st & 3'b000);
	assign rsp.address = (zero || c_st != ST_OK) ? '0 : dp_addr;
	assign rsp.compacted = (zero || c_st != ST_OK) ? 1'b0 : dp_pk;
endmodule

// File: dv/csa_checker.sv
// checker for the contiguous segment allocator: watches req/rsp, predicts, compares
// depends on csa_pkg
`timescale 1ns / 100ps
module csa_checker import csa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [15:0] cfg_data,
	input logic req_valid,
	input logic req_ready,
	input logic [1:0] req_action,
	input logic [3:0] req_pid,
	input logic [15:0] req_amount,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [15:0] rsp_address,
	input logic [2:0] rsp_status,
	input logic rsp_compacted,
	output int fail_count,
	output int pending
);
	localparam int NP = MAX_PROCESSES_DEF;

	typedef struct packed {
		logic [15:0] address;
		logic [2:0] status;
		logic compacted;
	} alloc_result_t;

	alloc_result_t result_q[$];
	logic [15:0] mem_words;
	logic seg_live[NP];
	logic [31:0] seg_base[NP];
	logic [31:0] seg_len[NP];
	int age_list[NP];
	int live_n;

	assign pending = result_q.size();

	function automatic logic [31:0] free_units();
		logic [31:0] used;
		used = 0;
		for (int i = 0; i < live_n; i++) used += seg_len[age_list[i]];
		return (used >= mem_words) ? 32'd0 : mem_words - used;
	endfunction

	function automatic alloc_result_t allocate(logic [1:0] act, int pid, logic [31:0] amt);
		alloc_result_t r;
		logic [31:0] base, run, oe;
		logic placed;
		int j;
		r = '0;
		base = 0;
		placed = 0;
		case (act)
			ACT_START: begin
				if (pid < NP && seg_live[pid]) r.status = ST_ACTIVE;
				else if (free_units() < amt) r.status = ST_NOSPACE;
				else if (amt < MIN_SEGMENT || pid >= NP || live_n >= NP) r.status = ST_SMALL;
				else begin
					if (live_n > 0) begin
						j = age_list[live_n-1];
						if (seg_base[j] + seg_len[j] + amt <= mem_words) begin
							base = seg_base[j] + seg_len[j];
							placed = 1;
						end
						for (int i = live_n - 1; !placed && i > 0; i--) begin
							oe = seg_base[age_list[i-1]] + seg_len[age_list[i-1]];
							if (oe < seg_base[age_list[i]] && seg_base[age_list[i]] - oe >= amt) begin
								base = oe;
								placed = 1;
							end
						end
						if (!placed) begin
							run = 0;
							for (int i = 0; i < live_n; i++) begin
								seg_base[age_list[i]] = run & 32'hFFFF;
								run += seg_len[age_list[i]];
							end
							base = run;
							r.compacted = 1;
						end
					end
					seg_live[pid] = 1;
					seg_base[pid] = base & 32'hFFFF;
					seg_len[pid] = amt;
					age_list[live_n] = pid;
					live_n++;
					r.address = base[15:0];
				end
			end
			ACT_STOP: begin
				if (pid >= NP || !seg_live[pid]) r.status = ST_INACTIVE;
				else begin
					seg_live[pid] = 0;
					j = 0;
					for (int i = 0; i < live_n; i++)
						if (age_list[i] != pid) begin
							age_list[j] = age_list[i];
							j++;
						end
					live_n = j;
				end
			end
			ACT_LOCATE: begin
				if (pid >= NP || !seg_live[pid]) r.status = ST_INACTIVE;
				else if (amt >= seg_len[pid]) r.status = ST_OFFSET;
				else r.address = 16'(seg_base[pid] + amt);
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t got, want;
		if (!arst_n) begin
			mem_words <= MEM_RESET;
			live_n = 0;
			for (int i = 0; i < NP; i++) seg_live[i] = 0;
			fail_count <= 0;
			result_q.delete();
		end else begin
			if (cfg_we) mem_words <= cfg_data;
			if (req_valid && req_ready)
				result_q.push_back(allocate(req_action, req_pid, {16'd0, req_amount}));
			if (rsp_valid && rsp_ready) begin
				got = '{rsp_address, rsp_status, rsp_compacted};
				if (result_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected word %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = result_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch: expected addr %0d st %0d cmp %0d, got %0d %0d %0d",
								want.address, want.status, want.compacted,
								got.address, got.status, got.compacted);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: dv/tb_contiguous_segment_allocator_core.sv
// testbench top for the contiguous segment allocator: stimulus and verdict
// depends on csa_pkg, csa_if, csa_checker and the core
`timescale 1ns / 100ps
module tb_contiguous_segment_allocator_core;
	import csa_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [15:0] cfg_data = 0;
	int fail_count, pending;
	int cycle = 0;
	int n_sent = 0;
	logic quiet = 0;
	logic hold_rsp = 0;
	logic stim_done = 0;

	csa_req_if req();
	csa_rsp_if #(.ADDR_BITS(16)) rsp();

	initial begin
		req.valid = 0;
		req.action = 0;
		req.process_id = 0;
		req.amount = 0;
		rsp.ready = 0;
	end

	always #5 clk = ~clk;

	contiguous_segment_allocator_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.req(req), .rsp(rsp)
	);

	csa_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.req_valid(req.valid), .req_ready(req.ready), .req_action(req.action),
		.req_pid(req.process_id), .req_amount(req.amount),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_address(rsp.address),
		.rsp_status(rsp.status), .rsp_compacted(rsp.compacted),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 600000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stall bursts, a long hold-off when asked, none at the end
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp.ready <= 0;
				repeat (400) @(posedge clk);
				rsp.ready <= 1;
				wait (!hold_rsp);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 17);
				rsp.ready <= 0;
				repeat (n - 1) @(posedge clk);
			end else rsp.ready <= 1;
		end
	end

	task automatic send_word(int act, int pid, int amt);
		int n;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 17);
			req.valid <= 0;
			repeat (n) @(posedge clk);
		end
		req.valid <= 1;
		req.action <= 2'(act);
		req.process_id <= 4'(pid);
		req.amount <= 16'(amt);
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		n_sent++;
	endtask

	task automatic idle_write(logic [15:0] v);
		@(posedge clk);
		req.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_phase(int count, int maxsz);
		int r;
		logic [15:0] amt;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			amt = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
				16'($urandom_range(0, maxsz));
			if (r < 45) send_word(ACT_START, $urandom_range(0, 9), amt);
			else if (r < 70) send_word(ACT_STOP, $urandom_range(0, 9), 0);
			else if (r < 94) send_word(ACT_LOCATE, $urandom_range(0, 9), amt);
			else send_word(2'($urandom_range(0, 3)), 4'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: checks order, tail placement and locate bounds
		send_word(ACT_START, 0, 100);
		send_word(ACT_START, 0, 5);
		send_word(ACT_START, 1, 9000);
		send_word(ACT_START, 1, 1);
		send_word(ACT_START, 1, 0);
		send_word(ACT_START, 12, 10);
		send_word(ACT_START, 15, 65535);
		send_word(ACT_START, 1, 7000);
		send_word(ACT_LOCATE, 0, 99);
		send_word(ACT_LOCATE, 0, 100);
		send_word(ACT_LOCATE, 15, 0);
		send_word(ACT_STOP, 14, 0);
		send_word(ACT_STOP, 0, 0);
		send_word(ACT_START, 2, 50);
		send_word(ACT_START, 3, 800);
		send_word(ACT_LOCATE, 3, 0);
		send_word(ACT_STOP, 2, 0);
		send_word(ACT_NONE, 15, 16'hFFFF);
		send_word(ACT_STOP, 2, 0);
		idle_write(16'd2);
		send_word(ACT_START, 4, 2);
		send_word(ACT_LOCATE, 1, 6999);
		idle_write(16'd65535);
		send_word(ACT_START, 5, 60000);
		send_word(ACT_START, 6, 200);
		// long receiver hold-off while the sender keeps offering
		hold_rsp <= 1;
		random_phase(20, 40);
		hold_rsp <= 0;
		idle_write(16'd300);
		random_phase(120, 60);
		idle_write(16'd40);
		random_phase(80, 12);
		idle_write(16'd65535);
		random_phase(60, 20000);
		idle_write(16'd8000);
		quiet <= 1;
		random_phase(100, 1500);
		@(posedge clk);
		req.valid <= 0;
		stim_done <= 1;
	end

	initial begin
		wait (stim_done);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule
